>>> hw/rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Concurrent checks, compiled out when SYNTH is defined.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`else

`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)

`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

>>> hw/rtl/iedbc_pkg.sv
// ---------------------------------------------------------------------------
// iedbc_pkg
// Request codes, register indexes and flag type of the boost controller.
// ---------------------------------------------------------------------------
package iedbc_pkg;

    localparam int REQ_WIDTH = 3;
    localparam int CFG_IDX_WIDTH = 3;

    typedef enum logic [REQ_WIDTH-1:0] {
        REQ_INPUT_EVENT = 3'd0,
        REQ_MAX_KICK    = 3'd1,
        REQ_SCREEN_ON   = 3'd2,
        REQ_SCREEN_OFF  = 3'd3,
        REQ_TICK        = 3'd4,
        REQ_QUERY       = 3'd5
    } t_req;

    localparam logic [CFG_IDX_WIDTH-1:0] CFG_LP_INPUT_FREQ    = 3'd0;
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_PERF_INPUT_FREQ  = 3'd1;
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_LP_MAX_FREQ      = 3'd2;
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_PERF_MAX_FREQ    = 3'd3;
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_INPUT_HOLD_TICKS = 3'd4;
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_WAKE_HOLD_TICKS  = 3'd5;

    typedef struct packed {
        logic max_on;
        logic input_on;
        logic display_off;
    } t_flags;

endpackage

>>> hw/rtl/iedbc_req_if.sv
// ---------------------------------------------------------------------------
// iedbc_req_if
// Request channel: valid/ready handshake with the request payload.
// ---------------------------------------------------------------------------
interface iedbc_req_if
    import iedbc_pkg::*;
#(
    parameter int FREQ_WIDTH  = 22,
    parameter int TIMER_WIDTH = 16
) ();
    logic                   valid;
    logic                   ready;
    logic [REQ_WIDTH-1:0]   req_type;
    logic [TIMER_WIDTH-1:0] kick_ticks;
    logic                   cluster_is_lp;
    logic [FREQ_WIDTH-1:0]  policy_max_freq;
    logic [FREQ_WIDTH-1:0]  hw_min_freq;

    modport source (
        output valid, req_type, kick_ticks, cluster_is_lp, policy_max_freq, hw_min_freq,
        input  ready
    );

    modport sink (
        input  valid, req_type, kick_ticks, cluster_is_lp, policy_max_freq, hw_min_freq,
        output ready
    );
endinterface

>>> hw/rtl/iedbc_rsp_if.sv
// ---------------------------------------------------------------------------
// iedbc_rsp_if
// Result channel: valid/ready handshake with flags and chosen frequency.
// ---------------------------------------------------------------------------
interface iedbc_rsp_if #(
    parameter int FREQ_WIDTH = 22
) ();
    logic                  valid;
    logic                  ready;
    logic                  screen_off_flag;
    logic                  input_boost_flag;
    logic                  max_boost_flag;
    logic                  flags_changed;
    logic [FREQ_WIDTH-1:0] floor_freq;

    modport source (
        output valid, screen_off_flag, input_boost_flag, max_boost_flag, flags_changed,
               floor_freq,
        input  ready
    );

    modport sink (
        input  valid, screen_off_flag, input_boost_flag, max_boost_flag, flags_changed,
               floor_freq,
        output ready
    );
endinterface

>>> hw/rtl/input_event_dvfs_boost_controller.sv
// ---------------------------------------------------------------------------
// input_event_dvfs_boost_controller
// Input-driven boost governor: flags, two countdown timers, minimum query.
// ---------------------------------------------------------------------------
// One request is taken per clock unless a consumer stall has filled both
// registers. The request lands in an input register, then the flag and timer
// update and the frequency choice run combinationally into the result
// register, which offers the result. The result register holds a result
// while the consumer stalls, and the input register holds one more request
// behind it. Throughput is one request per cycle while the consumer does not
// stall; the read-modify-write of the flags and the two timers in the second
// stage sets that figure.
`include "assert_macros.svh"

module input_event_dvfs_boost_controller
    import iedbc_pkg::*;
#(
    parameter int FREQ_WIDTH  = 22,
    parameter int TIMER_WIDTH = 16,
    localparam int CFG_WIDTH  = (FREQ_WIDTH > TIMER_WIDTH) ? FREQ_WIDTH : TIMER_WIDTH
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [CFG_IDX_WIDTH-1:0] i_cfg_idx,
    input  logic [CFG_WIDTH-1:0]     i_cfg_data,
    iedbc_req_if.sink                i_req,
    iedbc_rsp_if.source              o_rsp
);

    logic [FREQ_WIDTH-1:0]  r_lp_input_freq;
    logic [FREQ_WIDTH-1:0]  r_perf_input_freq;
    logic [FREQ_WIDTH-1:0]  r_lp_max_freq;
    logic [FREQ_WIDTH-1:0]  r_perf_max_freq;
    logic [TIMER_WIDTH-1:0] r_input_hold;
    logic [TIMER_WIDTH-1:0] r_wake_hold;

    logic                   r_in_valid;
    logic [REQ_WIDTH-1:0]   r_req_type;
    logic [TIMER_WIDTH-1:0] r_kick;
    logic                   r_is_lp;
    logic [FREQ_WIDTH-1:0]  r_pmax;
    logic [FREQ_WIDTH-1:0]  r_hwmin;

    t_flags                 r_flags;
    t_flags                 n_flags;
    logic [TIMER_WIDTH-1:0] r_input_rem;
    logic [TIMER_WIDTH-1:0] n_input_rem;
    logic [TIMER_WIDTH-1:0] r_max_rem;
    logic [TIMER_WIDTH-1:0] n_max_rem;
    logic [FREQ_WIDTH-1:0]  n_freq;

    logic                   r_out_valid;
    t_flags                 r_out_flags;
    logic                   r_out_changed;
    logic [FREQ_WIDTH-1:0]  r_out_freq;

    logic                   s_adv;
    logic [FREQ_WIDTH-1:0]  s_sel_freq;

    assign s_adv       = r_in_valid && (!r_out_valid || o_rsp.ready);
    assign i_req.ready = !r_in_valid || s_adv;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lp_input_freq   <= '0;
            r_perf_input_freq <= '0;
            r_lp_max_freq     <= '0;
            r_perf_max_freq   <= '0;
            r_input_hold      <= '0;
            r_wake_hold       <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_LP_INPUT_FREQ:    r_lp_input_freq   <= i_cfg_data[FREQ_WIDTH-1:0];
                CFG_PERF_INPUT_FREQ:  r_perf_input_freq <= i_cfg_data[FREQ_WIDTH-1:0];
                CFG_LP_MAX_FREQ:      r_lp_max_freq     <= i_cfg_data[FREQ_WIDTH-1:0];
                CFG_PERF_MAX_FREQ:    r_perf_max_freq   <= i_cfg_data[FREQ_WIDTH-1:0];
                CFG_INPUT_HOLD_TICKS: r_input_hold      <= i_cfg_data[TIMER_WIDTH-1:0];
                CFG_WAKE_HOLD_TICKS:  r_wake_hold       <= i_cfg_data[TIMER_WIDTH-1:0];
                default: begin
                end
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_req.ready) begin
            r_in_valid <= i_req.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.valid && i_req.ready) begin
            r_req_type <= i_req.req_type;
            r_kick     <= i_req.kick_ticks;
            r_is_lp    <= i_req.cluster_is_lp;
            r_pmax     <= i_req.policy_max_freq;
            r_hwmin    <= i_req.hw_min_freq;
        end
    end

    // flag and timer update, and frequency choice
    always_comb begin
        n_flags     = r_flags;
        n_input_rem = r_input_rem;
        n_max_rem   = r_max_rem;
        n_freq      = '0;
        s_sel_freq  = '0;
        case (t_req'(r_req_type))
            REQ_INPUT_EVENT: begin
                if (!r_flags.display_off) begin
                    n_flags.input_on = 1'b1;
                    n_input_rem      = r_input_hold;
                end
            end
            REQ_MAX_KICK: begin
                if (!r_flags.display_off && !(r_max_rem > r_kick)) begin
                    n_flags.max_on = 1'b1;
                    n_max_rem      = r_kick;
                end
            end
            REQ_SCREEN_ON: begin
                n_flags.display_off = 1'b0;
                if (!(r_max_rem > r_wake_hold)) begin
                    n_flags.max_on = 1'b1;
                    n_max_rem      = r_wake_hold;
                end
            end
            REQ_SCREEN_OFF: begin
                n_flags.display_off = 1'b1;
            end
            REQ_TICK: begin
                if (r_input_rem != '0) begin
                    n_input_rem = r_input_rem - 1'b1;
                end
                if (n_input_rem == '0) begin
                    n_flags.input_on = 1'b0;
                end
                if (r_max_rem != '0) begin
                    n_max_rem = r_max_rem - 1'b1;
                end
                if (n_max_rem == '0) begin
                    n_flags.max_on = 1'b0;
                end
            end
            REQ_QUERY: begin
                if (r_flags.display_off) begin
                    n_freq = r_hwmin;
                end else if (r_flags.max_on || r_flags.input_on) begin
                    if (r_flags.max_on) begin
                        s_sel_freq = r_is_lp ? r_lp_max_freq : r_perf_max_freq;
                    end else begin
                        s_sel_freq = r_is_lp ? r_lp_input_freq : r_perf_input_freq;
                    end
                    n_freq = (s_sel_freq < r_pmax) ? s_sel_freq : r_pmax;
                end else begin
                    n_freq = r_hwmin;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flags     <= '0;
            r_input_rem <= '0;
            r_max_rem   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (s_adv) begin
                r_flags     <= n_flags;
                r_input_rem <= n_input_rem;
                r_max_rem   <= n_max_rem;
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (s_adv) begin
            r_out_flags   <= n_flags;
            r_out_changed <= (n_flags != r_flags);
            r_out_freq    <= n_freq;
        end
    end

    assign o_rsp.valid            = r_out_valid;
    assign o_rsp.screen_off_flag  = r_out_flags.display_off;
    assign o_rsp.input_boost_flag = r_out_flags.input_on;
    assign o_rsp.max_boost_flag   = r_out_flags.max_on;
    assign o_rsp.flags_changed    = r_out_changed;
    assign o_rsp.floor_freq       = r_out_freq;

    `ASSERT_IMPLIES(a_input_idle_timer, i_clk, i_rst_n, !r_flags.input_on, r_input_rem == '0)
    `ASSERT_IMPLIES(a_max_idle_timer, i_clk, i_rst_n, !r_flags.max_on, r_max_rem == '0)
    `ASSERT_NEXT(a_rsp_held, i_clk, i_rst_n, r_out_valid && !o_rsp.ready, r_out_valid && $stable(r_out_freq))

endmodule

>>> dv/input_event_dvfs_boost_controller_tb.sv
// ---------------------------------------------------------------------------
// input_event_dvfs_boost_controller_tb
// Checks the boost controller: every request and result transfer runs over
// valid/ready, a local model tracks flags, timers and register values, and
// each result is compared field by field. A short directed run covers the
// corner cases. Random phases then follow under several register settings
// with sender gaps, receiver stalls, a long receiver hold-off and a sender
// pause.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module input_event_dvfs_boost_controller_tb;
    import iedbc_pkg::*;

    localparam int FW = 22;
    localparam int TW = 16;
    localparam int CW = (FW > TW) ? FW : TW;
    localparam logic [FW-1:0] FREQ_MAX = '1;
    localparam logic [TW-1:0] TICKS_MAX = '1;
    localparam logic [REQ_WIDTH-1:0] REQ_SPARE_6 = 3'd6;
    localparam logic [REQ_WIDTH-1:0] REQ_SPARE_7 = 3'd7;
    localparam int STALL_LIMIT = 3000;
    localparam int HOLD_OFF_CYCLES = 80;

    typedef struct {
        logic [REQ_WIDTH-1:0] code;
        logic [TW-1:0]        kick_ticks;
        logic                 cluster_is_lp;
        logic [FW-1:0]        policy_max_freq;
        logic [FW-1:0]        hw_min_freq;
    } t_boost_request;

    typedef struct {
        t_flags        flags;
        logic          flags_changed;
        logic [FW-1:0] floor_freq;
    } t_boost_status;

    class boost_tracker;
        logic [FW-1:0]   lp_input_freq;
        logic [FW-1:0]   perf_input_freq;
        logic [FW-1:0]   lp_max_freq;
        logic [FW-1:0]   perf_max_freq;
        logic [TW-1:0]   input_hold_ticks;
        logic [TW-1:0]   wake_hold_ticks;
        t_flags          flags;
        logic [TW-1:0]   input_left;
        logic [TW-1:0]   max_left;
        t_boost_status   expected_status[$];
        int              n_mismatch;

        function new();
            lp_input_freq    = '0;
            perf_input_freq  = '0;
            lp_max_freq      = '0;
            perf_max_freq    = '0;
            input_hold_ticks = '0;
            wake_hold_ticks  = '0;
            flags            = '0;
            input_left       = '0;
            max_left         = '0;
            n_mismatch       = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_WIDTH-1:0] idx, logic [CW-1:0] value);
            case (idx)
                CFG_LP_INPUT_FREQ:    lp_input_freq    = value[FW-1:0];
                CFG_PERF_INPUT_FREQ:  perf_input_freq  = value[FW-1:0];
                CFG_LP_MAX_FREQ:      lp_max_freq      = value[FW-1:0];
                CFG_PERF_MAX_FREQ:    perf_max_freq    = value[FW-1:0];
                CFG_INPUT_HOLD_TICKS: input_hold_ticks = value[TW-1:0];
                CFG_WAKE_HOLD_TICKS:  wake_hold_ticks  = value[TW-1:0];
                default: ;
            endcase
        endfunction

        function void arm_max(logic [TW-1:0] ticks);
            if (!flags.display_off && max_left <= ticks) begin
                max_left = ticks;
                flags.max_on = 1'b1;
            end
        endfunction

        function int pending();
            return expected_status.size();
        endfunction

        function void note_request(t_boost_request r);
            t_flags        prior;
            t_boost_status s;
            logic [FW-1:0] boost_freq;
            prior = flags;
            s.floor_freq = '0;
            case (r.code)
                REQ_INPUT_EVENT: begin
                    if (!flags.display_off) begin
                        flags.input_on = 1'b1;
                        input_left = input_hold_ticks;
                    end
                end
                REQ_MAX_KICK: arm_max(r.kick_ticks);
                REQ_SCREEN_ON: begin
                    flags.display_off = 1'b0;
                    arm_max(wake_hold_ticks);
                end
                REQ_SCREEN_OFF: flags.display_off = 1'b1;
                REQ_TICK: begin
                    if (input_left != 0) input_left = input_left - 1'b1;
                    if (input_left == 0) flags.input_on = 1'b0;
                    if (max_left != 0) max_left = max_left - 1'b1;
                    if (max_left == 0) flags.max_on = 1'b0;
                end
                REQ_QUERY: begin
                    if (flags.display_off || !(flags.max_on || flags.input_on)) begin
                        s.floor_freq = r.hw_min_freq;
                    end else begin
                        if (flags.max_on) begin
                            boost_freq = r.cluster_is_lp ? lp_max_freq : perf_max_freq;
                        end else begin
                            boost_freq = r.cluster_is_lp ? lp_input_freq : perf_input_freq;
                        end
                        s.floor_freq = (boost_freq < r.policy_max_freq) ? boost_freq
                                                                        : r.policy_max_freq;
                    end
                end
                default: ;
            endcase
            s.flags = flags;
            s.flags_changed = (flags != prior);
            expected_status.push_back(s);
        endfunction

        task report(string msg);
            if (n_mismatch < 40) $display("[%0t] mismatch: %s", $time, msg);
            n_mismatch++;
        endtask

        task check_status(t_boost_status got);
            t_boost_status want;
            if (expected_status.size() == 0) begin
                report("result transfer with nothing expected");
                return;
            end
            want = expected_status.pop_front();
            if (got.flags.display_off !== want.flags.display_off)
                report($sformatf("screen_off_flag got %b want %b",
                                 got.flags.display_off, want.flags.display_off));
            if (got.flags.input_on !== want.flags.input_on)
                report($sformatf("input_boost_flag got %b want %b",
                                 got.flags.input_on, want.flags.input_on));
            if (got.flags.max_on !== want.flags.max_on)
                report($sformatf("max_boost_flag got %b want %b",
                                 got.flags.max_on, want.flags.max_on));
            if (got.flags_changed !== want.flags_changed)
                report($sformatf("flags_changed got %b want %b",
                                 got.flags_changed, want.flags_changed));
            if (got.floor_freq !== want.floor_freq)
                report($sformatf("floor_freq got 0x%0h want 0x%0h",
                                 got.floor_freq, want.floor_freq));
        endtask
    endclass

    logic                     i_clk = 1'b0;
    logic                     i_rst_n;
    logic                     i_cfg_we;
    logic [CFG_IDX_WIDTH-1:0] i_cfg_idx;
    logic [CW-1:0]            i_cfg_data;

    iedbc_req_if #(.FREQ_WIDTH(FW), .TIMER_WIDTH(TW)) req_ch ();
    iedbc_rsp_if #(.FREQ_WIDTH(FW)) rsp_ch ();

    input_event_dvfs_boost_controller #(
        .FREQ_WIDTH (FW),
        .TIMER_WIDTH(TW)
    ) dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg_we  (i_cfg_we),
        .i_cfg_idx (i_cfg_idx),
        .i_cfg_data(i_cfg_data),
        .i_req     (req_ch),
        .o_rsp     (rsp_ch)
    );

    boost_tracker tracker = new();
    int  tx_idle_pct = 0;
    int  rx_stall_pct = 0;
    bit  hold_request = 1'b0;
    int  stalled_cycles = 0;

    always #4 i_clk = ~i_clk;

    // receiver: random stalls, plus one long hold-off on request
    always @(posedge i_clk) begin
        static int hold_left = 0;
        static bit hold_done = 1'b0;
        if (hold_request && !hold_done) begin
            hold_left = HOLD_OFF_CYCLES;
            hold_done = 1'b1;
        end
        if (hold_left > 0) begin
            rsp_ch.ready <= 1'b0;
            hold_left--;
        end else begin
            rsp_ch.ready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        t_boost_status got;
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
            got.flags.display_off = rsp_ch.screen_off_flag;
            got.flags.input_on    = rsp_ch.input_boost_flag;
            got.flags.max_on      = rsp_ch.max_boost_flag;
            got.flags_changed     = rsp_ch.flags_changed;
            got.floor_freq        = rsp_ch.floor_freq;
            tracker.check_status(got);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_we || (req_ch.valid && req_ch.ready)
                || (rsp_ch.valid && rsp_ch.ready)) begin
            stalled_cycles = 0;
        end else begin
            stalled_cycles++;
            if (stalled_cycles >= STALL_LIMIT) begin
                $display("input_event_dvfs_boost_controller_tb NOT OK");
                $finish;
            end
        end
    end

    task write_reg(logic [CFG_IDX_WIDTH-1:0] idx, logic [CW-1:0] value);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        tracker.set_reg(idx, value);
        @(posedge i_clk);
    endtask

    task apply_settings(logic [FW-1:0] lp_in, logic [FW-1:0] perf_in,
                        logic [FW-1:0] lp_max, logic [FW-1:0] perf_max,
                        logic [TW-1:0] in_hold, logic [TW-1:0] wake_hold);
        write_reg(CFG_LP_INPUT_FREQ, CW'(lp_in));
        write_reg(CFG_PERF_INPUT_FREQ, CW'(perf_in));
        write_reg(CFG_LP_MAX_FREQ, CW'(lp_max));
        write_reg(CFG_PERF_MAX_FREQ, CW'(perf_max));
        write_reg(CFG_INPUT_HOLD_TICKS, CW'(in_hold));
        write_reg(CFG_WAKE_HOLD_TICKS, CW'(wake_hold));
        i_cfg_we <= 1'b0;
    endtask

    task wait_drained();
        do @(posedge i_clk); while (tracker.pending() != 0);
    endtask

    task send_request(t_boost_request r);
        req_ch.valid           <= 1'b1;
        req_ch.req_type        <= r.code;
        req_ch.kick_ticks      <= r.kick_ticks;
        req_ch.cluster_is_lp   <= r.cluster_is_lp;
        req_ch.policy_max_freq <= r.policy_max_freq;
        req_ch.hw_min_freq     <= r.hw_min_freq;
        do @(posedge i_clk); while (!req_ch.ready);
        tracker.note_request(r);
    endtask

    function automatic t_boost_request make_req(logic [REQ_WIDTH-1:0] code,
                                                logic [TW-1:0] kick, logic lp,
                                                logic [FW-1:0] pmax, logic [FW-1:0] hwmin);
        t_boost_request r;
        r.code = code;
        r.kick_ticks = kick;
        r.cluster_is_lp = lp;
        r.policy_max_freq = pmax;
        r.hw_min_freq = hwmin;
        return r;
    endfunction

    function automatic logic [FW-1:0] rand_freq();
        case ($urandom_range(7))
            0: return '0;
            1: return FREQ_MAX;
            default: return FW'($urandom);
        endcase
    endfunction

    function automatic t_boost_request make_random(bit allow_long);
        t_boost_request r;
        int pick;
        pick = $urandom_range(99);
        r.kick_ticks = TW'($urandom);
        r.cluster_is_lp = 1'($urandom_range(1));
        r.policy_max_freq = rand_freq();
        r.hw_min_freq = rand_freq();
        if (pick < 20) begin
            r.code = REQ_INPUT_EVENT;
        end else if (pick < 35) begin
            r.code = REQ_MAX_KICK;
            if (!(allow_long && $urandom_range(3) == 0))
                r.kick_ticks = TW'($urandom_range(6));
        end else if (pick < 42) begin
            r.code = REQ_SCREEN_ON;
        end else if (pick < 47) begin
            r.code = REQ_SCREEN_OFF;
        end else if (pick < 77) begin
            r.code = REQ_TICK;
        end else if (pick < 97) begin
            r.code = REQ_QUERY;
        end else begin
            r.code = $urandom_range(1) ? REQ_SPARE_7 : REQ_SPARE_6;
        end
        return r;
    endfunction

    task run_phase(int n_items, int tx_idle, int rx_stall, bit allow_long, int pause_at);
        int k;
        tx_idle_pct = tx_idle;
        rx_stall_pct = rx_stall;
        for (k = 0; k < n_items; k++) begin
            if (k == pause_at) begin
                req_ch.valid <= 1'b0;
                wait_drained();
            end
            while ($urandom_range(99) < tx_idle_pct) begin
                req_ch.valid <= 1'b0;
                @(posedge i_clk);
            end
            send_request(make_random(allow_long));
        end
        req_ch.valid <= 1'b0;
    endtask

    initial begin
        t_boost_request script[$];
        i_rst_n                <= 1'b0;
        i_cfg_we               <= 1'b0;
        i_cfg_idx              <= CFG_LP_INPUT_FREQ;
        i_cfg_data             <= '0;
        req_ch.valid           <= 1'b0;
        req_ch.req_type        <= REQ_INPUT_EVENT;
        req_ch.kick_ticks      <= '0;
        req_ch.cluster_is_lp   <= 1'b0;
        req_ch.policy_max_freq <= '0;
        req_ch.hw_min_freq     <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        apply_settings(FREQ_MAX, 22'h155555, 22'h2AAAAA, '0, 16'd2, 16'd0);
        script.push_back(make_req(REQ_QUERY, '0, 1'b1, FREQ_MAX, '0));
        script.push_back(make_req(REQ_SPARE_6, TICKS_MAX, 1'b1, FREQ_MAX, FREQ_MAX));
        script.push_back(make_req(REQ_SPARE_7, '0, 1'b0, '0, '0));
        script.push_back(make_req(REQ_TICK, '0, 1'b0, '0, '0));
        script.push_back(make_req(REQ_INPUT_EVENT, '0, 1'b0, '0, '0));
        script.push_back(make_req(REQ_QUERY, '0, 1'b1, FREQ_MAX, FREQ_MAX));
        script.push_back(make_req(REQ_QUERY, '0, 1'b0, 22'h0FFFFF, '0));
        script.push_back(make_req(REQ_MAX_KICK, '0, 1'b0, '0, '0));
        script.push_back(make_req(REQ_QUERY, '0, 1'b1, 22'h000123, FREQ_MAX));
        script.push_back(make_req(REQ_TICK, '0, 1'b0, '0, '0));
        script.push_back(make_req(REQ_MAX_KICK, 16'd3, 1'b0, '0, '0));
        script.push_back(make_req(REQ_MAX_KICK, 16'd3, 1'b0, '0, '0));
        script.push_back(make_req(REQ_MAX_KICK, 16'd1, 1'b0, '0, '0));
        script.push_back(make_req(REQ_SCREEN_OFF, '0, 1'b0, '0, '0));
        script.push_back(make_req(REQ_INPUT_EVENT, '0, 1'b0, '0, '0));
        script.push_back(make_req(REQ_MAX_KICK, TICKS_MAX, 1'b0, '0, '0));
        script.push_back(make_req(REQ_QUERY, '0, 1'b1, '0, FREQ_MAX));
        script.push_back(make_req(REQ_TICK, '0, 1'b0, '0, '0));
        script.push_back(make_req(REQ_TICK, '0, 1'b0, '0, '0));
        script.push_back(make_req(REQ_SCREEN_ON, '0, 1'b0, '0, '0));
        script.push_back(make_req(REQ_MAX_KICK, TICKS_MAX, 1'b0, '0, '0));
        script.push_back(make_req(REQ_TICK, '0, 1'b0, '0, '0));
        script.push_back(make_req(REQ_QUERY, '0, 1'b0, '0, FREQ_MAX));
        script.push_back(make_req(REQ_QUERY, '0, 1'b1, FREQ_MAX, '0));
        foreach (script[k]) send_request(script[k]);
        req_ch.valid <= 1'b0;
        wait_drained();

        // hold the receiver off while the sender keeps offering
        apply_settings(rand_freq(), rand_freq(), rand_freq(), rand_freq(), 16'd3, 16'd5);
        hold_request = 1'b1;
        run_phase(180, 0, 0, 1'b0, -1);
        wait_drained();

        apply_settings(FREQ_MAX, FREQ_MAX, FREQ_MAX, FREQ_MAX, 16'd1, 16'd1);
        run_phase(180, 69, 0, 1'b0, 90);
        wait_drained();

        apply_settings('0, '0, '0, '0, '0, '0);
        run_phase(180, 0, 69, 1'b0, -1);
        wait_drained();

        apply_settings(rand_freq(), rand_freq(), rand_freq(), rand_freq(),
                       TICKS_MAX, TICKS_MAX);
        run_phase(180, 9, 9, 1'b1, -1);
        wait_drained();
        repeat (10) @(posedge i_clk);

        if (tracker.n_mismatch == 0 && tracker.pending() == 0) begin
            $display("input_event_dvfs_boost_controller_tb OK");
        end else begin
            $display("input_event_dvfs_boost_controller_tb NOT OK");
        end
        $finish;
    end

endmodule
